// File: rtl/core/wsc_pkg.sv
// ----------------------------------------------------------------------------
// wsc_pkg
// types and constants shared by the waypoint steering control block
// ----------------------------------------------------------------------------
package wsc_pkg;

	localparam int X_W        = 28;
	localparam int MAX_STAGES = 24;
	localparam int PADDR_W    = 5;
	localparam int PDATA_W    = 32;

	// arctan(2^-i) in units of 2^32 per turn
	localparam logic [31:0] ATAN_TURN32 [MAX_STAGES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	// cordic gain correction, Q0.16
	localparam logic [15:0] DIST_SCALE = 16'd39797;
	localparam logic [31:0] HALF_TURN  = 32'h8000_0000;

	localparam logic [2:0] REG_STOP_DISTANCE  = 3'd0;
	localparam logic [2:0] REG_TURN_THRESHOLD = 3'd1;
	localparam logic [2:0] REG_FORWARD_SPEED  = 3'd2;
	localparam logic [2:0] REG_ROTATE_RATE    = 3'd3;
	localparam logic [2:0] REG_STEER_GAIN     = 3'd4;

	typedef enum logic [1:0] {
		MODE_STOP    = 2'd0,
		MODE_ROTATE  = 2'd1,
		MODE_FORWARD = 2'd2
	} drive_mode_t;

	typedef struct packed {
		logic signed [15:0] pose_x;
		logic signed [15:0] pose_y;
		logic signed [15:0] pose_yaw;
		logic signed [15:0] goal_x;
		logic signed [15:0] goal_y;
	} pose_item_t;

	typedef struct packed {
		logic        [14:0] linear_cmd;
		logic signed [15:0] angular_cmd;
		logic signed [15:0] heading_error;
		drive_mode_t        drive_mode;
		logic               goal_reached;
	} cmd_item_t;

	typedef struct packed {
		logic        [14:0] stop_distance;
		logic        [14:0] turn_threshold;
		logic        [14:0] forward_speed;
		logic signed [15:0] rotate_rate;
		logic        [15:0] steer_gain;
	} wsc_cfg_t;

	typedef struct packed {
		logic signed [X_W-1:0] x;
		logic signed [X_W-1:0] y;
		logic        [31:0]    z;
		logic        [15:0]    yaw;
	} cordic_vec_t;

endpackage

// File: rtl/core/wsc_regs.sv
// ----------------------------------------------------------------------------
// wsc_regs
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
module wsc_regs import wsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output wsc_cfg_t           cfg
);

	wsc_cfg_t   cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[PADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_distance  <= 15'd64;
			cfg_q.turn_threshold <= 15'd1820;
			cfg_q.forward_speed  <= 15'd26;
			cfg_q.rotate_rate    <= 16'sd26;
			cfg_q.steer_gain     <= 16'd922;
		end else if (wr_en) begin
			unique case (idx)
				REG_STOP_DISTANCE:  cfg_q.stop_distance  <= pwdata[14:0];
				REG_TURN_THRESHOLD: cfg_q.turn_threshold <= pwdata[14:0];
				REG_FORWARD_SPEED:  cfg_q.forward_speed  <= pwdata[14:0];
				REG_ROTATE_RATE:    cfg_q.rotate_rate    <= $signed(pwdata[15:0]);
				REG_STEER_GAIN:     cfg_q.steer_gain     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_STOP_DISTANCE:  prdata = {17'd0, cfg_q.stop_distance};
			REG_TURN_THRESHOLD: prdata = {17'd0, cfg_q.turn_threshold};
			REG_FORWARD_SPEED:  prdata = {17'd0, cfg_q.forward_speed};
			REG_ROTATE_RATE:    prdata = {16'd0, cfg_q.rotate_rate};
			REG_STEER_GAIN:     prdata = {16'd0, cfg_q.steer_gain};
			default:            prdata = '0;
		endcase
	end

endmodule

// File: rtl/core/wsc_cordic_stage.sv
// ----------------------------------------------------------------------------
// wsc_cordic_stage
// one registered vectoring micro-rotation
// ----------------------------------------------------------------------------
module wsc_cordic_stage import wsc_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  cordic_vec_t in_vec,
	output logic        out_valid,
	input  logic        out_ready,
	output cordic_vec_t out_vec
);

	localparam logic [4:0]  IDX   = 5'(STAGE);
	localparam logic [31:0] ANGLE = ATAN_TURN32[IDX];

	logic signed [X_W-1:0] x, y, xs, ys;
	cordic_vec_t           nxt;
	cordic_vec_t           vec_s1;
	logic                  vld_s1;

	assign in_ready  = !vld_s1 || out_ready;
	assign out_valid = vld_s1;
	assign out_vec   = vec_s1;

	always_comb begin
		x   = in_vec.x;
		y   = in_vec.y;
		xs  = x >>> STAGE;
		ys  = y >>> STAGE;
		nxt = in_vec;
		if (y > 0) begin
			nxt.x = x + ys;
			nxt.y = y - xs;
			nxt.z = in_vec.z + ANGLE;
		end else begin
			nxt.x = x - ys;
			nxt.y = y + xs;
			nxt.z = in_vec.z - ANGLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			vec_s1 <= nxt;
		end
	end

endmodule

// File: rtl/core/wsc_cordic.sv
// ----------------------------------------------------------------------------
// wsc_cordic
// offset forming, half-turn pre-rotation and pipelined cordic vectoring
// ----------------------------------------------------------------------------
module wsc_cordic import wsc_pkg::*; #(
	parameter int STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  pose_item_t  in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output cordic_vec_t out_vec
);

	cordic_vec_t           vec [STAGES+1];
	logic [STAGES:0]       vld;
	logic [STAGES:0]       rdy;
	logic signed [16:0]    dx, dy;
	logic signed [X_W-1:0] x0, y0;
	cordic_vec_t           pre;
	cordic_vec_t           pre_s1;
	logic                  pre_vld_s1;

	always_comb begin
		dx      = 17'(in_item.goal_x) - 17'(in_item.pose_x);
		dy      = 17'(in_item.goal_y) - 17'(in_item.pose_y);
		x0      = {{(X_W-25){dx[16]}}, dx, 8'd0};
		y0      = {{(X_W-25){dy[16]}}, dy, 8'd0};
		pre.yaw = in_item.pose_yaw;
		if (x0 < 0) begin
			pre.x = -x0;
			pre.y = -y0;
			pre.z = HALF_TURN;
		end else begin
			pre.x = x0;
			pre.y = y0;
			pre.z = '0;
		end
	end

	assign in_ready = !pre_vld_s1 || rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_vld_s1 <= 1'b0;
		end else if (in_ready) begin
			pre_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pre_s1 <= pre;
		end
	end

	assign vec[0]      = pre_s1;
	assign vld[0]      = pre_vld_s1;
	assign rdy[STAGES] = out_ready;

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		wsc_cordic_stage #(
			.STAGE(k)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (vld[k]),
			.in_ready (rdy[k]),
			.in_vec   (vec[k]),
			.out_valid(vld[k+1]),
			.out_ready(rdy[k+1]),
			.out_vec  (vec[k+1])
		);
	end

	assign out_valid = vld[STAGES];
	assign out_vec   = vec[STAGES];

endmodule

// File: rtl/core/wsc_steer.sv
// ----------------------------------------------------------------------------
// wsc_steer
// heading error, distance scaling, mode choice and command register
// ----------------------------------------------------------------------------
module wsc_steer import wsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  wsc_cfg_t    cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  cordic_vec_t in_vec,
	output logic        out_valid,
	input  logic        out_ready,
	output cmd_item_t   out_item
);

	logic [31:0]        z_rnd;
	logic [15:0]        err_c;
	logic [26:0]        xcl_c;

	logic               vld_s1, vld_s2, vld_s3;
	logic               rdy1, rdy2, rdy3;
	logic signed [15:0] err_s1, err_s2;
	logic [26:0]        xcl_s1;
	logic [42:0]        dist_prod_s2;
	logic signed [32:0] steer_prod_s2;
	cmd_item_t          cmd_s3;

	logic [43:0]        dist_sum;
	logic [19:0]        dist_c;
	logic signed [16:0] ang_w;
	logic signed [15:0] ang_sat;
	cmd_item_t          cmd_c;

	assign rdy3     = !vld_s3 || out_ready;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		z_rnd = in_vec.z + 32'h0000_8000;
		err_c = z_rnd[31:16] - in_vec.yaw;
		xcl_c = in_vec.x[X_W-1] ? '0 : in_vec.x[26:0];
	end

	always_comb begin
		dist_sum = 44'(dist_prod_s2) + 44'h80_0000;
		dist_c   = dist_sum[43:24];
		ang_w    = steer_prod_s2[32:16];
		if (ang_w[16] != ang_w[15]) begin
			ang_sat = ang_w[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			ang_sat = ang_w[15:0];
		end
		cmd_c.heading_error = err_s2;
		priority if (dist_c <= {5'd0, cfg.stop_distance}) begin
			cmd_c.drive_mode   = MODE_STOP;
			cmd_c.goal_reached = 1'b1;
			cmd_c.linear_cmd   = '0;
			cmd_c.angular_cmd  = '0;
		end else if (err_s2 > $signed({1'b0, cfg.turn_threshold})) begin
			cmd_c.drive_mode   = MODE_ROTATE;
			cmd_c.goal_reached = 1'b0;
			cmd_c.linear_cmd   = '0;
			cmd_c.angular_cmd  = cfg.rotate_rate;
		end else begin
			cmd_c.drive_mode   = MODE_FORWARD;
			cmd_c.goal_reached = 1'b0;
			cmd_c.linear_cmd   = cfg.forward_speed;
			cmd_c.angular_cmd  = ang_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				vld_s1 <= in_valid;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			err_s1 <= err_c;
			xcl_s1 <= xcl_c;
		end
		if (rdy2 && vld_s1) begin
			err_s2        <= err_s1;
			dist_prod_s2  <= 43'(xcl_s1) * 43'(DIST_SCALE);
			steer_prod_s2 <= 33'(err_s1) * $signed({17'd0, cfg.steer_gain});
		end
		if (rdy3 && vld_s2) begin
			cmd_s3 <= cmd_c;
		end
	end

	assign out_valid = vld_s3;
	assign out_item  = cmd_s3;

endmodule

// File: rtl/core/waypoint_steering_control.sv
// ----------------------------------------------------------------------------
// waypoint_steering_control
// go-to-goal heading controller for a single waypoint
// ----------------------------------------------------------------------------
// pose channel (pose_valid / pose_ready / pose) takes robot pose and goal point;
// cmd channel (cmd_valid / cmd_ready / cmd) returns one command item per pose
// item: linear and angular command, heading error, drive mode, reached flag.
// thresholds, speeds and gain are set over the apb-style port; pready is tied
// high and a write lands at the access phase.
// from pose accept to cmd valid an item passes one input register, one register
// per cordic micro-rotation, then error, multiply and command registers. a new
// pose item is taken every cycle while cmd_ready stays high.
// every stage holds its own valid bit, so when cmd_ready is low the pipeline
// keeps filling empty stages and pose_ready drops only once all are full.
// reset empties the pipeline and loads the register defaults; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module waypoint_steering_control import wsc_pkg::*; #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               pose_valid,
	output logic               pose_ready,
	input  pose_item_t         pose,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output cmd_item_t          cmd
);

	localparam int NSTG = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

	wsc_cfg_t    cfg;
	logic        vec_valid;
	logic        vec_ready;
	cordic_vec_t vec;

	wsc_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	wsc_cordic #(
		.STAGES(NSTG)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pose_valid),
		.in_ready (pose_ready),
		.in_item  (pose),
		.out_valid(vec_valid),
		.out_ready(vec_ready),
		.out_vec  (vec)
	);

	wsc_steer u_steer (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (vec_valid),
		.in_ready (vec_ready),
		.in_vec   (vec),
		.out_valid(cmd_valid),
		.out_ready(cmd_ready),
		.out_item (cmd)
	);

endmodule

// File: rtl/core/wsc_checker.sv
// ----------------------------------------------------------------------------
// wsc_checker
// port-level checks on the command channel
// ----------------------------------------------------------------------------
module wsc_checker import wsc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_ready,
	input cmd_item_t cmd
);

	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
		else $error("cmd item changed while stalled");

	a_reached_mode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> (cmd.goal_reached == (cmd.drive_mode == MODE_STOP)))
		else $error("reached flag disagrees with drive mode");

	a_linear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd.drive_mode != MODE_FORWARD |-> cmd.linear_cmd == '0)
		else $error("linear command outside forward mode");

	a_stop_still: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd.drive_mode == MODE_STOP |-> cmd.angular_cmd == '0)
		else $error("angular command while stopped");

	a_rotate_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd.drive_mode == MODE_ROTATE |-> cmd.heading_error > 0)
		else $error("rotation with non-positive heading error");

endmodule

bind waypoint_steering_control wsc_checker u_wsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_ready(cmd_ready),
	.cmd      (cmd)
);
